FILE: rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/ps2sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2sc_pkg;

	localparam logic [7:0] SC_PFX_EXT   = 8'hE0;
	localparam logic [7:0] SC_PFX_PAUSE = 8'hE1;
	localparam logic [6:0] SC_LSHIFT    = 7'h2A;
	localparam logic [6:0] SC_RSHIFT    = 7'h36;
	localparam logic [6:0] SC_CTRL      = 7'h1D;
	localparam logic [6:0] SC_ENTER     = 7'h1C;
	localparam logic [6:0] SC_BACK      = 7'h0E;
	localparam logic [6:0] SC_CAPS      = 7'h3A;
	localparam logic [6:0] SC_KP_SLASH  = 7'h65;
	localparam logic [6:0] SC_ALT_BACK  = 7'h5B;
	localparam logic [6:0] SC_ALT_ENTER = 7'h5C;
	localparam logic [7:0] CTRL_MASK    = 8'h1F;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_BRACKET   = 8'h5B;
	localparam logic [7:0] CH_TILDE     = 8'h7E;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CASE_BIT     = 8'h20;
	localparam logic [2:0] PAUSE_SKIP   = 3'd2;
	localparam logic [2:0] RUN_MAX      = 3'd5;

	localparam logic [7:0] KEYMAP_PLAIN [128] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h1B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h0E, 8'h1C, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25
	};

	localparam logic [7:0] KEYMAP_SHIFT [128] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h1B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h08, 8'h0A, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25
	};

	typedef struct packed {
		logic       shift_held;
		logic       ctrl_held;
		logic       caps_on;
		logic       extended_pending;
		logic [1:0] pause_bytes_left;
	} kbd_state_t;

	// Entry 0 of a run is the key event, entries 1 to 4 are characters.
	typedef struct packed {
		logic            valid;
		logic [2:0]      len;
		logic [6:0]      key_code;
		logic            is_extended;
		logic            is_release;
		logic [3:0][7:0] chars;
	} run_t;

	typedef struct packed {
		logic       hit;
		logic       tilde;
		logic [7:0] final_char;
	} nav_seq_t;

	// The caps layouts follow from the plain and shift layouts by flipping
	// letter case, apart from a few shifted keys that keep their unshifted code and keypad slash, which gives 8'h3F.
	function automatic logic [7:0] keymap_lookup(input logic caps, input logic shift,
		input logic [6:0] code);
		logic [7:0] ch;
		ch = shift ? KEYMAP_SHIFT[code] : KEYMAP_PLAIN[code];
		if (caps) begin
			if (!shift) begin
				if (ch >= 8'h61 && ch <= 8'h7A) begin
					ch = ch ^ CASE_BIT;
				end
			end else begin
				if (ch >= 8'h41 && ch <= 8'h5A) begin
					ch = ch ^ CASE_BIT;
				end
				if (code == SC_ENTER) begin
					ch = 8'h00;
				end else if (code == SC_ALT_BACK) begin
					ch = KEYMAP_PLAIN[SC_ALT_BACK];
				end else if (code == SC_ALT_ENTER) begin
					ch = KEYMAP_PLAIN[SC_ALT_ENTER];
				end else if (code == SC_KP_SLASH) begin
					ch = 8'h3F;
				end
			end
		end
		return ch;
	endfunction

	function automatic nav_seq_t nav_lookup(input logic [7:0] b);
		nav_seq_t s;
		s = '0;
		case (b)
			8'h48: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h41};
			8'h50: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h42};
			8'h4B: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h44};
			8'h4D: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h43};
			8'h47: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h48};
			8'h4F: s = '{hit: 1'b1, tilde: 1'b0, final_char: 8'h46};
			8'h49: s = '{hit: 1'b1, tilde: 1'b1, final_char: 8'h35};
			8'h51: s = '{hit: 1'b1, tilde: 1'b1, final_char: 8'h36};
			8'h52: s = '{hit: 1'b1, tilde: 1'b1, final_char: 8'h32};
			8'h53: s = '{hit: 1'b1, tilde: 1'b1, final_char: 8'h33};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ps2sc_xlate.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2sc_xlate
	import ps2sc_pkg::*;
(
	input  wire logic [7:0] scan_byte,
	input  wire kbd_state_t cur,
	output kbd_state_t      nxt,
	output run_t            run
);

	logic [6:0] code;
	logic       rel;
	logic [7:0] ch;
	logic [7:0] ch_masked;
	nav_seq_t   nav;

	assign code      = scan_byte[6:0];
	assign rel       = scan_byte[7];
	assign ch        = keymap_lookup(cur.caps_on, cur.shift_held, code);
	assign ch_masked = cur.ctrl_held ? (ch & CTRL_MASK) : ch;
	assign nav       = nav_lookup(scan_byte);

	always_comb begin
		nxt = cur;
		run = '0;
		if (cur.pause_bytes_left != 2'd0) begin
			nxt.pause_bytes_left = cur.pause_bytes_left - 2'd1;
		end else if (cur.extended_pending) begin
			nxt.extended_pending = 1'b0;
			run.valid            = 1'b1;
			run.len              = 3'd1;
			run.key_code         = code;
			run.is_extended      = 1'b1;
			run.is_release       = rel;
			if (nav.hit) begin
				run.chars[0] = CH_ESC;
				run.chars[1] = CH_BRACKET;
				run.chars[2] = nav.final_char;
				run.chars[3] = CH_TILDE;
				run.len      = nav.tilde ? 3'd5 : 3'd4;
			end
		end else if (scan_byte == SC_PFX_EXT) begin
			nxt.extended_pending = 1'b1;
		end else if (scan_byte == SC_PFX_PAUSE) begin
			nxt.pause_bytes_left = PAUSE_SKIP[1:0];
		end else begin
			run.valid    = 1'b1;
			run.len      = 3'd1;
			run.key_code = code;
			run.is_release = rel;
			if (rel) begin
				if (code == SC_LSHIFT || code == SC_RSHIFT) begin
					nxt.shift_held = 1'b0;
				end else if (code == SC_CTRL) begin
					nxt.ctrl_held = 1'b0;
				end
			end else if (ch != 8'h00) begin
				if (ch_masked != 8'h00) begin
					run.chars[0] = ch_masked;
					run.len      = 3'd2;
				end
			end else begin
				case (code)
					SC_ENTER: begin
						run.chars[0] = CH_NEWLINE;
						run.len      = 3'd2;
					end
					SC_BACK: begin
						run.chars[0] = CH_BACKSPACE;
						run.len      = 3'd2;
					end
					SC_LSHIFT, SC_RSHIFT: nxt.shift_held = 1'b1;
					SC_CTRL: nxt.ctrl_held = 1'b1;
					SC_CAPS: nxt.caps_on = ~cur.caps_on;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ps2_scancode_to_ascii_unit.sv
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] scan_byte
// m_axis    out  tdata key event or character, tuser out_kind, tlast last_of_run
//
// A byte is taken into the input register and translated on the way into the
// run register; its results then leave at one beat per cycle while m_axis_tready
// is high. A further byte waits in the input register while a run drains on the
// single output port; the run register reloads as the last beat of its run leaves.
// Reset clears the keyboard state and both valid flags at once.
// While m_axis_tready is low the current beat holds and one more byte is buffered.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ps2_scancode_to_ascii_unit
	import ps2sc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] scan_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [6:0] key_code, [7] is_extended, [8] is_release, [16:9] char_byte, [23:17] zero
	output logic [23:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // [0] out_kind
	output logic             m_axis_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	kbd_state_t state_q;
	kbd_state_t state_nxt;
	run_t       run_nxt;
	run_t       run_q;
	logic [2:0] idx_q;
	logic [1:0] char_sel;
	logic       out_beat;
	logic       run_free;
	logic       take_s1;

	ps2sc_xlate u_xlate (
		.scan_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.run       (run_nxt)
	);

	assign out_beat      = m_axis_tvalid && m_axis_tready;
	assign run_free      = !run_q.valid || (out_beat && m_axis_tlast);
	assign take_s1       = valid_s1 && run_free;
	assign s_axis_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			run_q   <= '0;
			idx_q   <= 3'd0;
		end else if (take_s1) begin
			state_q <= state_nxt;
			run_q   <= run_nxt;
			idx_q   <= 3'd0;
		end else if (out_beat) begin
			if (m_axis_tlast) begin
				run_q.valid <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign char_sel      = 2'(idx_q - 3'd1);
	assign m_axis_tvalid = run_q.valid;
	assign m_axis_tuser  = (idx_q != 3'd0);
	assign m_axis_tlast  = (idx_q == run_q.len - 3'd1);

	always_comb begin
		if (idx_q == 3'd0) begin
			m_axis_tdata = {7'd0, 8'h00, run_q.is_release, run_q.is_extended,
				run_q.key_code};
		end else begin
			m_axis_tdata = {7'd0, run_q.chars[char_sel], 1'b0, 1'b0, 7'd0};
		end
	end

	`ASSERT_CLK(a_run_len, clk, arst_n, run_q.valid |-> (run_q.len != 3'd0 && run_q.len <= RUN_MAX))
	`ASSERT_CLK(a_idx_in_run, clk, arst_n, run_q.valid |-> (idx_q < run_q.len))
	`ASSERT_CLK(a_run_advance, clk, arst_n, (out_beat && !m_axis_tlast) |=> (run_q.valid && idx_q == $past(idx_q) + 3'd1))
	`ASSERT_NEVER(a_prefix_excl, clk, arst_n, state_q.extended_pending && state_q.pause_bytes_left != 2'd0)
	`ASSERT_NEVER(a_pause_range, clk, arst_n, state_q.pause_bytes_left == 2'd3)

endmodule

`default_nettype wire
